[src/fq_pkg.sv]
// fq_pkg: operation codes, status codes and word width shared by the
// positional-delete FIFO. No dependencies.
`timescale 1ns / 1ps

package fq_pkg;

	localparam int DATA_W = 32;

	// operation codes on the request channel
	localparam logic [1:0] OP_ENQ = 2'd0;
	localparam logic [1:0] OP_DEQ = 2'd1;
	localparam logic [1:0] OP_DEL = 2'd2;

	// status codes on the response channel
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_OVERFLOW = 2'd1;
	localparam logic [1:0] ST_EMPTY    = 2'd2;
	localparam logic [1:0] ST_BADPOS   = 2'd3;

endpackage

[src/fq_if.sv]
// fq_if: request and response channel interfaces (valid/ready) of the FIFO.
// Depends on fq_pkg for the word width.
`timescale 1ns / 1ps

interface fq_req_if #(parameter int POS_W = 7);
	logic                             valid;
	logic                             ready;
	logic [1:0]                       opcode;
	logic signed [fq_pkg::DATA_W-1:0] value;
	logic [POS_W-1:0]                 position;

	modport source (output valid, output opcode, output value, output position, input ready);
	modport sink (input valid, input opcode, input value, input position, output ready);
endinterface

interface fq_rsp_if #(parameter int CNT_W = 7);
	logic                             valid;
	logic                             ready;
	logic signed [fq_pkg::DATA_W-1:0] data;
	logic [1:0]                       status;
	logic [CNT_W-1:0]                 occupancy;

	modport source (output valid, output data, output status, output occupancy, input ready);
	modport sink (input valid, input data, input status, input occupancy, output ready);
endinterface

[src/fifo_with_positional_delete_core.sv]
// Bounded FIFO of signed 32-bit words with enqueue, dequeue and
// delete-at-position (1-based from the head, order of the rest kept).
//
// Channels: req (opcode, value, position) and rsp (data, status, occupancy),
// both valid/ready; an item moves when valid and ready are high at a clock edge.
// Every request yields exactly one response. Status: ok, overflow, empty or
// underflow, invalid position. Data is the dequeued or deleted word, else zero.
//
// Timing: req.ready is high only while the sequencer is idle. Enqueue, errors
// and the unused opcode go from idle straight to the done state; dequeue
// passes through the read-wait state; delete also passes through the shift
// state when entries lie behind it, moving one entry toward the head per cycle,
// as the store's read and write ports and the shared slot adder handle one each.
// The next request is taken the cycle after the response register loads.
//
// Reset (arst_n low) empties the queue and drops any pending response; the
// entry store keeps no reset. If rsp.ready stays low, the finished response
// waits in its register and the sequencer holds until it is taken.
`timescale 1ns / 1ps

module fifo_with_positional_delete_core #(
	parameter int DEPTH = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	fq_req_if.sink    req,
	fq_rsp_if.source  rsp
);

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_RDWAIT = 4'b0010,
		S_SHIFT  = 4'b0100,
		S_DONE   = 4'b1000
	} state_t;

	state_t                           state_q;
	logic [1:0]                       op_q;
	logic [IDX_W-1:0]                 head_q;
	logic [CNT_W-1:0]                 count_q;
	logic [CNT_W-1:0]                 idx_q;
	logic [IDX_W-1:0]                 gap_slot_q;
	logic [IDX_W-1:0]                 rd_slot_q;
	logic signed [fq_pkg::DATA_W-1:0] res_data_q;
	logic [1:0]                       res_status_q;
	logic                             rsp_valid_q;
	logic signed [fq_pkg::DATA_W-1:0] rsp_data_q;
	logic [1:0]                       rsp_status_q;
	logic [CNT_W-1:0]                 rsp_occ_q;

	logic [CNT_W-1:0]                 offset;
	logic [IDX_W-1:0]                 slot;
	logic                             accept;
	logic                             full;
	logic                             empty;
	logic                             pos_bad;
	logic                             more;
	logic                             rsp_load;
	logic                             mem_we;
	logic [IDX_W-1:0]                 mem_waddr;
	logic signed [fq_pkg::DATA_W-1:0] mem_wdata;
	logic                             mem_re;
	logic signed [fq_pkg::DATA_W-1:0] mem_rdata;

	assign req.ready     = (state_q == S_IDLE);
	assign accept        = req.valid && req.ready;
	assign full          = (count_q == CNT_W'(DEPTH));
	assign empty         = (count_q == '0);
	assign pos_bad       = (req.position == '0) || (req.position > count_q);
	assign more          = (offset < count_q);
	assign rsp_load      = (state_q == S_DONE) && (!rsp_valid_q || rsp.ready);
	assign rsp.valid     = rsp_valid_q;
	assign rsp.data      = rsp_data_q;
	assign rsp.status    = rsp_status_q;
	assign rsp.occupancy = rsp_occ_q;

	// select the offset from the head for the shared slot adder
	always_comb begin
		offset = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req.opcode == fq_pkg::OP_ENQ) begin
					offset = count_q;
				end else if (req.opcode == fq_pkg::OP_DEL) begin
					offset = req.position - CNT_W'(1);
				end
			end
			S_RDWAIT: offset = idx_q + CNT_W'(1);
			S_SHIFT:  offset = idx_q + CNT_W'(2);
			S_DONE:   offset = '0;
			default:  offset = '0;
		endcase
	end

	fq_slot #(
		.DEPTH (DEPTH),
		.IDX_W (IDX_W),
		.CNT_W (CNT_W)
	) u_slot (
		.head   (head_q),
		.offset (offset),
		.slot   (slot)
	);

	// drive the store: append on enqueue, move one entry per shift cycle
	always_comb begin
		mem_we = ((state_q == S_IDLE) && accept && (req.opcode == fq_pkg::OP_ENQ) && !full)
			|| (state_q == S_SHIFT);
		mem_waddr = (state_q == S_SHIFT) ? gap_slot_q : slot;
		mem_wdata = (state_q == S_SHIFT) ? mem_rdata : req.value;
		mem_re = ((state_q == S_IDLE) && accept && !empty
				&& ((req.opcode == fq_pkg::OP_DEQ)
				|| ((req.opcode == fq_pkg::OP_DEL) && !pos_bad)))
			|| ((state_q == S_RDWAIT) && (op_q == fq_pkg::OP_DEL) && more)
			|| ((state_q == S_SHIFT) && more);
	end

	fq_mem #(
		.DEPTH (DEPTH),
		.IDX_W (IDX_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (slot),
		.rdata (mem_rdata)
	);

	// sequencer, queue pointers and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (mem_re) begin
							state_q <= S_RDWAIT;
						end else begin
							state_q <= S_DONE;
						end
						if ((req.opcode == fq_pkg::OP_ENQ) && !full) begin
							count_q <= count_q + CNT_W'(1);
						end
					end
				end
				S_RDWAIT: begin
					if ((op_q == fq_pkg::OP_DEL) && more) begin
						state_q <= S_SHIFT;
					end else begin
						state_q <= S_DONE;
						count_q <= count_q - CNT_W'(1);
						if (count_q == CNT_W'(1)) begin
							head_q <= '0;
						end else if (op_q == fq_pkg::OP_DEQ) begin
							head_q <= slot;
						end
					end
				end
				S_SHIFT: begin
					if (!more) begin
						state_q <= S_DONE;
						count_q <= count_q - CNT_W'(1);
					end
				end
				S_DONE: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// operation context, shift pointers and response payload
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q       <= req.opcode;
					idx_q      <= (req.opcode == fq_pkg::OP_DEL) ? offset : '0;
					gap_slot_q <= slot;
					res_data_q <= '0;
					if ((req.opcode == fq_pkg::OP_ENQ) && full) begin
						res_status_q <= fq_pkg::ST_OVERFLOW;
					end else if (((req.opcode == fq_pkg::OP_DEQ)
							|| (req.opcode == fq_pkg::OP_DEL)) && empty) begin
						res_status_q <= fq_pkg::ST_EMPTY;
					end else if ((req.opcode == fq_pkg::OP_DEL) && pos_bad) begin
						res_status_q <= fq_pkg::ST_BADPOS;
					end else begin
						res_status_q <= fq_pkg::ST_OK;
					end
				end
			end
			S_RDWAIT: begin
				res_data_q <= mem_rdata;
				rd_slot_q  <= slot;
			end
			S_SHIFT: begin
				gap_slot_q <= rd_slot_q;
				rd_slot_q  <= slot;
				idx_q      <= idx_q + CNT_W'(1);
			end
			S_DONE: begin
				if (rsp_load) begin
					rsp_data_q   <= res_data_q;
					rsp_status_q <= res_status_q;
					rsp_occ_q    <= count_q;
				end
			end
			default: begin
			end
		endcase
	end

	// the count never passes the store depth
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count exceeds depth");

	// an empty queue keeps its head at slot zero
	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (head_q == '0))
		else $error("head not reset on empty queue");

	// the store is written only on an enqueue acceptance or a shift step
	assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> ((state_q == S_IDLE) || (state_q == S_SHIFT)))
		else $error("store write outside enqueue or shift");

	// an overflow response reports a full queue
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && (rsp_status_q == fq_pkg::ST_OVERFLOW))
			|-> (rsp_occ_q == CNT_W'(DEPTH)))
		else $error("overflow reported on a queue that is not full");

	// an empty or underflow response reports zero entries
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && (rsp_status_q == fq_pkg::ST_EMPTY)) |-> (rsp_occ_q == '0))
		else $error("empty reported on a queue that holds entries");

endmodule

[src/fq_mem.sv]
// fq_mem: entry store of the FIFO, one write port and one registered read port.
// Depends on fq_pkg for the word width.
`timescale 1ns / 1ps

module fq_mem #(
	parameter int DEPTH = 64,
	parameter int IDX_W = 6
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [IDX_W-1:0]                 waddr,
	input  logic signed [fq_pkg::DATA_W-1:0] wdata,
	input  logic                             re,
	input  logic [IDX_W-1:0]                 raddr,
	output logic signed [fq_pkg::DATA_W-1:0] rdata
);

	logic signed [fq_pkg::DATA_W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[src/fq_slot.sv]
// fq_slot: shared address unit, maps an offset from the head to a store slot
// with circular wrap. No package dependencies.
`timescale 1ns / 1ps

module fq_slot #(
	parameter int DEPTH = 64,
	parameter int IDX_W = 6,
	parameter int CNT_W = 7
) (
	input  logic [IDX_W-1:0] head,
	input  logic [CNT_W-1:0] offset,
	output logic [IDX_W-1:0] slot
);

	localparam int SUM_W = CNT_W + 1;

	logic [SUM_W-1:0] sum;

	// add and wrap once: head < DEPTH and offset <= DEPTH keep the sum below 2*DEPTH
	always_comb begin
		sum = SUM_W'(head) + SUM_W'(offset);
		if (sum >= SUM_W'(DEPTH)) begin
			slot = IDX_W'(sum - SUM_W'(DEPTH));
		end else begin
			slot = IDX_W'(sum);
		end
	end

endmodule

[tb/fq_checker.sv]
// fq_checker: watches both channels of the positional-delete FIFO, keeps its
// own copy of the queue and compares every response with the predicted one.
// Depends on fq_pkg and the channel interfaces in fq_if.sv.
`timescale 1ns / 1ps

module fq_checker #(
	parameter int DEPTH = 64
) (
	input  logic clk,
	input  logic arst_n,
	fq_req_if    req,
	fq_rsp_if    rsp,
	output int   errors,
	output int   outstanding
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef struct packed {
		logic signed [fq_pkg::DATA_W-1:0] data;
		logic [1:0]                       status;
		logic [CNT_W-1:0]                 occupancy;
	} fq_result_t;

	// mirror of the queue, head at index 0
	logic signed [fq_pkg::DATA_W-1:0] held_words[$];
	fq_result_t                       awaited_results[$];
	int                               error_count = 0;

	assign errors = error_count;

	// apply one request to the mirror and return the response it must give
	function automatic fq_result_t apply_request(logic [1:0] op,
			logic signed [fq_pkg::DATA_W-1:0] val, logic [CNT_W-1:0] pos);
		fq_result_t r;
		int         idx;
		r.data   = '0;
		r.status = fq_pkg::ST_OK;
		idx      = int'(pos);
		case (op)
			fq_pkg::OP_ENQ: begin
				if (held_words.size() >= DEPTH)
					r.status = fq_pkg::ST_OVERFLOW;
				else
					held_words.push_back(val);
			end
			fq_pkg::OP_DEQ: begin
				if (held_words.size() == 0)
					r.status = fq_pkg::ST_EMPTY;
				else
					r.data = held_words.pop_front();
			end
			fq_pkg::OP_DEL: begin
				// the empty check wins over the position check
				if (held_words.size() == 0) begin
					r.status = fq_pkg::ST_EMPTY;
				end else if (idx < 1 || idx > held_words.size()) begin
					r.status = fq_pkg::ST_BADPOS;
				end else begin
					r.data = held_words[idx-1];
					held_words.delete(idx - 1);
				end
			end
			default: ;
		endcase
		r.occupancy = CNT_W'(held_words.size());
		return r;
	endfunction

	task automatic flag_mismatch(string what, longint want, longint got);
		if (error_count < 40)
			$display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
		error_count++;
	endtask

	// compare accepted responses first, then record the request taken on this edge
	always @(posedge clk or negedge arst_n) begin
		fq_result_t want;
		if (!arst_n) begin
			held_words.delete();
			awaited_results.delete();
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (awaited_results.size() == 0) begin
					if (error_count < 40)
						$display("%0t: response with none expected: data %0d status %0d occ %0d",
							$time, rsp.data, rsp.status, rsp.occupancy);
					error_count++;
				end else begin
					want = awaited_results.pop_front();
					if (rsp.data !== want.data)
						flag_mismatch("data", want.data, rsp.data);
					if (rsp.status !== want.status)
						flag_mismatch("status", want.status, rsp.status);
					if (rsp.occupancy !== want.occupancy)
						flag_mismatch("occupancy", want.occupancy, rsp.occupancy);
				end
			end
			if (req.valid && req.ready)
				awaited_results.push_back(apply_request(req.opcode, req.value, req.position));
		end
		outstanding = awaited_results.size();
	end

endmodule

[tb/tb.sv]
// tb: drives the positional-delete FIFO core with directed and random items,
// stalls both channels and reports the verdict from fq_checker.
// Depends on fq_pkg, fq_if.sv, the core and tb/fq_checker.sv.
`timescale 1ns / 1ps

module tb;

	localparam int         DEPTH     = 64;
	localparam int         POS_W     = $clog2(DEPTH + 1);
	localparam int         ITEM_GOAL = 400;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n;
	int   errors;
	int   outstanding;
	int   hold_requests = 0;
	int   queue_fill = 0;
	int   items_sent = 0;
	int   burst_left = 0;

	fq_req_if #(.POS_W(POS_W)) req_ch ();
	fq_rsp_if #(.CNT_W(POS_W)) rsp_ch ();

	fifo_with_positional_delete_core #(.DEPTH(DEPTH)) dut (
		.clk, .arst_n, .req(req_ch), .rsp(rsp_ch)
	);

	fq_checker #(.DEPTH(DEPTH)) u_checker (
		.clk, .arst_n, .req(req_ch), .rsp(rsp_ch), .errors, .outstanding
	);

	always #5 clk = ~clk;

	function automatic logic signed [fq_pkg::DATA_W-1:0] random_word();
		case ($urandom_range(0, 11))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	// mostly legal positions, plus zero, past the tail and anything at all
	function automatic logic [POS_W-1:0] random_position();
		int k;
		k = $urandom_range(0, 9);
		if (k < 7 && queue_fill > 0)
			return POS_W'($urandom_range(1, queue_fill));
		else if (k == 7)
			return '0;
		else if (k == 8)
			return POS_W'($urandom_range(queue_fill + 1, (1 << POS_W) - 1));
		return POS_W'($urandom);
	endfunction

	// offer one item at the falling edge and hold it until it is taken
	task automatic send_item(input logic [1:0] op,
			input logic signed [fq_pkg::DATA_W-1:0] val, input logic [POS_W-1:0] pos);
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) != 0) begin
				req_ch.valid    = 1'b0;
				req_ch.opcode   = 2'($urandom);
				req_ch.value    = $urandom;
				req_ch.position = POS_W'($urandom);
				repeat ($urandom_range(1, 8)) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
				: $urandom_range(1, 12);
		end
		burst_left--;
		req_ch.valid    = 1'b1;
		req_ch.opcode   = op;
		req_ch.value    = val;
		req_ch.position = pos;
		// track the fill level only to steer the random mix
		case (op)
			fq_pkg::OP_ENQ: if (queue_fill < DEPTH) queue_fill++;
			fq_pkg::OP_DEQ: if (queue_fill > 0) queue_fill--;
			fq_pkg::OP_DEL:
				if (queue_fill > 0 && int'(pos) >= 1 && int'(pos) <= queue_fill) queue_fill--;
			default: ;
		endcase
		items_sent++;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
	endtask

	task automatic send_random(input int enq_weight);
		int k;
		k = $urandom_range(0, 99);
		if (k < enq_weight)
			send_item(fq_pkg::OP_ENQ, random_word(), POS_W'($urandom));
		else if (k < enq_weight + (97 - enq_weight) * 2 / 5)
			send_item(fq_pkg::OP_DEQ, random_word(), POS_W'($urandom));
		else if (k < 97)
			send_item(fq_pkg::OP_DEL, random_word(), random_position());
		else
			send_item(OP_UNUSED, random_word(), POS_W'($urandom));
	endtask

	// drop valid and wait for every response to come back
	task automatic drain_responses();
		req_ch.valid = 1'b0;
		burst_left   = 0;
		wait (outstanding == 0);
		@(negedge clk);
	endtask

	// stimulus
	initial begin
		int phase;
		req_ch.valid    = 1'b0;
		req_ch.opcode   = fq_pkg::OP_ENQ;
		req_ch.value    = '0;
		req_ch.position = '0;
		arst_n          = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// errors on an empty queue and the unused opcode
		send_item(fq_pkg::OP_DEQ, 32'sd0, 7'd0);
		send_item(fq_pkg::OP_DEL, 32'sd0, 7'd1);
		send_item(OP_UNUSED, 32'sh1234_5678, 7'd5);
		// extreme words
		send_item(fq_pkg::OP_ENQ, 32'sh8000_0000, 7'd0);
		send_item(fq_pkg::OP_ENQ, 32'sh7fff_ffff, 7'd127);
		send_item(fq_pkg::OP_ENQ, 32'sd0, 7'd0);
		send_item(fq_pkg::OP_ENQ, -32'sd1, 7'd0);
		send_item(fq_pkg::OP_ENQ, 32'sh5555_5555, 7'd0);
		send_item(fq_pkg::OP_ENQ, 32'shaaaa_aaaa, 7'd0);
		// bad positions: zero, largest, one past the tail
		send_item(fq_pkg::OP_DEL, 32'sd0, 7'd0);
		send_item(fq_pkg::OP_DEL, 32'sd0, 7'd127);
		send_item(fq_pkg::OP_DEL, 32'sd0, 7'd7);
		// delete at tail, head and middle
		send_item(fq_pkg::OP_DEL, 32'sd0, 7'd6);
		send_item(fq_pkg::OP_DEL, 32'sd0, 7'd1);
		send_item(fq_pkg::OP_DEL, 32'sd0, 7'd2);
		send_item(OP_UNUSED, -32'sd1, 7'd127);
		// empty the queue, then underflow and delete on empty
		send_item(fq_pkg::OP_DEQ, 32'sd0, 7'd0);
		send_item(fq_pkg::OP_DEQ, 32'sd0, 7'd0);
		send_item(fq_pkg::OP_DEQ, 32'sd0, 7'd0);
		send_item(fq_pkg::OP_DEQ, 32'sd0, 7'd0);
		send_item(fq_pkg::OP_DEL, 32'sd0, 7'd1);
		drain_responses();

		// fill to full, mix, drain to empty, over and over
		phase = 0;
		while (items_sent < ITEM_GOAL) begin
			case (phase % 3)
				0: begin
					if (phase == 0 || phase == 3)
						hold_requests++;
					while (queue_fill < DEPTH)
						send_random(85);
					repeat (3) send_item(fq_pkg::OP_ENQ, random_word(), POS_W'($urandom));
					send_item(fq_pkg::OP_DEL, random_word(), POS_W'(DEPTH));
					send_item(fq_pkg::OP_DEL, random_word(), POS_W'(1));
				end
				1: begin
					repeat (40) send_random(50);
				end
				default: begin
					while (queue_fill > 0)
						send_random(15);
					send_item(fq_pkg::OP_DEQ, random_word(), POS_W'($urandom));
					send_item(fq_pkg::OP_DEL, random_word(), POS_W'(1));
					drain_responses();
				end
			endcase
			phase++;
		end

		// wait out the tail, then give the verdict
		req_ch.valid = 1'b0;
		wait (outstanding == 0);
		repeat (80) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// response side: stall patterns, plus a long hold-off on request
	initial begin
		int holds_done;
		int mode;
		int span;
		holds_done   = 0;
		rsp_ch.ready = 1'b0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			if (hold_requests > holds_done) begin
				holds_done++;
				rsp_ch.ready = 1'b0;
				repeat (400) @(negedge clk);
			end
			mode = $urandom_range(0, 3);
			span = $urandom_range(10, 60);
			repeat (span) begin
				case (mode)
					0: rsp_ch.ready = 1'b1;
					1: rsp_ch.ready = 1'($urandom_range(0, 1));
					2: rsp_ch.ready = ($urandom_range(0, 3) == 0);
					default: rsp_ch.ready = ($urandom_range(0, 7) != 0);
				endcase
				@(negedge clk);
			end
		end
	end

	// hang guard
	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
